/* hdl/cli_pkg.sv */
package cli_pkg;

    // Field widths
    localparam int IN_W     = 16;
    localparam int GAIN_W   = 31;
    localparam int DIV_W    = 16;
    localparam int LIMIT_W  = 15;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // Accumulator format
    localparam int FRACTION_BITS = 16;
    localparam int WHOLE_W = 16;
    localparam int ACC_W   = 32;

    // Serial multiplier: error magnitude plus one, times Ki
    localparam int MAG_W  = 16;
    localparam int PROD_W = ACC_W + MAG_W;

    localparam int DIV_CNT_W = $clog2(GAIN_W);
    localparam int MUL_CNT_W = $clog2(MAG_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DIVISOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd200;

    // Clamp status codes
    localparam logic [STATUS_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] CLAMP_LOW  = 2'd1;
    localparam logic [STATUS_W-1:0] CLAMP_HIGH = 2'd2;

    localparam logic [ACC_W-1:0] INC_POS_SAT = 32'h7fff_ffff;
    localparam logic [ACC_W-1:0] INC_NEG_SAT = 32'h8000_0000;

endpackage

/* hdl/cli_serial_div.sv */
// Restoring divider, one quotient bit per cycle.
module cli_serial_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cli_pkg::GAIN_W-1:0]   dividend,
    input  logic [cli_pkg::DIV_W-1:0]    divisor,
    output logic                         done,
    output logic [cli_pkg::GAIN_W-1:0]   quotient
);
    import cli_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [GAIN_W-1:0]     num_reg, num_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W:0]        trial;
    logic                  ge;
    logic                  last;

    assign trial = {rem_reg, num_reg[GAIN_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign last  = cnt_reg == DIV_CNT_W'(GAIN_W - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // quotient bits fill the low end as dividend bits leave the top
            num_next = {num_reg[GAIN_W-2:0], ge};
            rem_next = ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

/* hdl/cli_serial_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module cli_serial_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cli_pkg::GAIN_W-1:0]   multiplicand,
    input  logic [cli_pkg::MAG_W-1:0]    multiplier,
    output logic                         done,
    output logic [cli_pkg::PROD_W-1:0]   product
);
    import cli_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [MUL_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [GAIN_W-1:0]     mcand_reg, mcand_next;
    logic [ACC_W-1:0]      hi_reg, hi_next;
    logic [MAG_W-1:0]      lo_reg, lo_next;
    logic [ACC_W:0]        add_sum;
    logic                  last;

    assign add_sum = {1'b0, hi_reg} + (lo_reg[0] ? (ACC_W + 1)'(mcand_reg) : '0);
    assign last    = cnt_reg == MUL_CNT_W'(MAG_W - 1);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = multiplicand;
            hi_next    = '0;
            lo_next    = multiplier;
        end
        else if (busy_reg)
        begin
            hi_next  = add_sum[ACC_W:1];
            lo_next  = {add_sum[0], lo_reg[MAG_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

/* hdl/current_loop_integrator_unit.sv */
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  --------------------------------------
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    measured_current, current_reference
// out      out        out_valid / out_ready  integral_value, clamp_status
//
// One item at a time. With a non-zero divisor the item passes through the serial
// divider producing Ki, the serial multiplier, a step that forms the increment
// and a step that adds and clamps. A zero divisor skips the arithmetic and goes
// straight to the add-and-clamp step.
// Reset (rst_n low, async) clears the integrator and loads the register defaults.
// A waiting result does not block the next item; only the add stage stalls on it.
// cfg_ready is always high.
module current_loop_integrator_unit (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cli_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cli_pkg::GAIN_W-1:0]       cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cli_pkg::IN_W-1:0]         measured_current,
    input  logic [cli_pkg::IN_W-1:0]         current_reference,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cli_pkg::LIMIT_W-1:0]      integral_value,
    output logic [cli_pkg::STATUS_W-1:0]     clamp_status
);
    import cli_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;

    // Configuration registers
    logic [GAIN_W-1:0]   gain_reg;
    logic [DIV_W-1:0]    divisor_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // Integrator state, 16.FRACTION_BITS
    logic [WHOLE_W-1:0]        whole_reg, whole_next;
    logic [FRACTION_BITS-1:0]  frac_reg, frac_next;

    logic [2:0]          state_reg, state_next;
    logic                hold_reg;       // zero divisor: integrator held
    logic                neg_reg;        // error sign
    logic [MAG_W-1:0]    magp1_reg;      // |error| + 1
    logic [ACC_W-1:0]    inc_reg, inc_next;

    logic                out_valid_reg, out_valid_next;
    logic [LIMIT_W-1:0]  value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                accept;
    logic                load;
    logic                div_start, div_done, mul_done;
    logic [GAIN_W-1:0]   ki;
    logic [PROD_W-1:0]   prod;

    logic [IN_W-1:0]     diff;
    logic [MAG_W-1:0]    mag;
    logic                sat;
    logic [ACC_W-1:0]    mag_ki;
    logic [ACC_W-1:0]    whole_ext, acc, sum, top, clamped;
    logic [1:0]          combo;          // 0 both non-negative, 1 both negative, 2 mixed

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == S_IDLE;
    assign accept    = in_valid && in_ready;
    assign div_start = accept && (divisor_reg != '0);
    assign load      = (state_reg == S_ADD) && (!out_valid_reg || out_ready);

    // Error is the wrapped 16-bit difference read as signed
    assign diff = measured_current - current_reference;
    assign mag  = diff[IN_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    cli_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (gain_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (ki)
    );

    // (|err| + 1) * Ki: saturation when it exceeds 0x7fffffff, i.e. when
    // |err| >= 0x7fffffff / Ki; otherwise |err| * Ki is the product less Ki.
    cli_serial_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_done),
        .multiplicand (ki),
        .multiplier   (magp1_reg),
        .done         (mul_done),
        .product      (prod)
    );

    assign sat    = |prod[PROD_W-1:GAIN_W];
    assign mag_ki = prod[ACC_W-1:0] - ACC_W'(ki);

    always_comb
    begin
        if (sat)
            inc_next = neg_reg ? INC_NEG_SAT : INC_POS_SAT;
        else if (neg_reg)
            inc_next = -mag_ki;
        else
            inc_next = mag_ki;
    end

    // Add to the accumulator, then clamp to 0 .. limit
    assign whole_ext = {{(ACC_W - WHOLE_W){whole_reg[WHOLE_W-1]}}, whole_reg};
    assign acc       = (whole_ext << FRACTION_BITS) | ACC_W'(frac_reg);
    assign sum       = inc_reg + acc;
    assign top       = ACC_W'(limit_reg) << FRACTION_BITS;

    always_comb
    begin
        if (!inc_reg[ACC_W-1] && !whole_ext[ACC_W-1])
            combo = 2'd0;
        else if (inc_reg[ACC_W-1] && whole_ext[ACC_W-1])
            combo = 2'd1;
        else
            combo = 2'd2;
    end

    always_comb
    begin
        clamped     = sum;
        status_next = CLAMP_NONE;
        if (combo == 2'd0 && sum[ACC_W-1])
        begin
            // positive overflow
            clamped     = top;
            status_next = CLAMP_HIGH;
        end
        else if (combo == 2'd1 && !sum[ACC_W-1])
        begin
            // negative overflow
            clamped     = '0;
            status_next = CLAMP_LOW;
        end
        else if (sum[ACC_W-1])
        begin
            clamped     = '0;
            status_next = CLAMP_LOW;
        end
        else if (sum >= top)
        begin
            clamped     = top;
            status_next = CLAMP_HIGH;
        end
        if (hold_reg)
            status_next = CLAMP_NONE;
    end

    always_comb
    begin
        whole_next = whole_reg;
        frac_next  = frac_reg;
        if (load && !hold_reg)
        begin
            whole_next = WHOLE_W'(clamped >> FRACTION_BITS);
            frac_next  = clamped[FRACTION_BITS-1:0];
        end
    end

    assign value_next = whole_next[LIMIT_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (divisor_reg != '0) ? S_DIV : S_ADD;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            whole_reg     <= '0;
            frac_reg      <= '0;
            gain_reg      <= '0;
            divisor_reg   <= '0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            whole_reg     <= whole_next;
            frac_reg      <= frac_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_SCALE:   gain_reg    <= cfg_data;
                    REG_KI_DIVISOR:   divisor_reg <= cfg_data[DIV_W-1:0];
                    REG_OUTPUT_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Per-item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg  <= divisor_reg == '0;
            neg_reg   <= diff[IN_W-1];
            magp1_reg <= mag + 1'b1;
        end
        if (state_reg == S_FIX)
            inc_reg <= inc_next;
        if (load)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign integral_value = value_reg;
    assign clamp_status   = status_reg;

    // Checks

    // Clamping keeps the integer part non-negative
    a_whole_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !whole_reg[WHOLE_W-1])
        else $error("integrator integer part went negative");

    // A result clamped high carries the limit itself
    a_high_is_limit: assert property (@(posedge clk) disable iff (!rst_n)
        load && status_next == CLAMP_HIGH |=> integral_value == $past(limit_reg))
        else $error("high clamp does not report the limit");

    // Zero divisor skips the arithmetic and holds the integrator
    a_zero_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && divisor_reg == '0 |=> state_reg == S_ADD && hold_reg)
        else $error("zero divisor did not take the hold path");

    // Divider completes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

endmodule

/* bench/tb_current_loop_integrator_unit.sv */
module tb_current_loop_integrator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import cli_pkg::*;

    // Expected item on the result channel
    typedef struct packed {
        logic [LIMIT_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } integrator_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data = '0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [IN_W-1:0]      measured_current = '0;
    logic [IN_W-1:0]      current_reference = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LIMIT_W-1:0]   integral_value;
    logic [STATUS_W-1:0]  clamp_status;

    // Shadow copy of the registers, tracked from accepted writes
    logic [GAIN_W-1:0]    gain_shadow  = '0;
    logic [DIV_W-1:0]     div_shadow   = '0;
    logic [LIMIT_W-1:0]   limit_shadow = LIMIT_RESET;

    // Shadow copy of the 16.16 accumulator
    logic [WHOLE_W-1:0]       acc_whole = '0;
    logic [FRACTION_BITS-1:0] acc_frac  = '0;

    integrator_out_t expected_integrals[$];
    int unsigned     samples_sent      = 0;
    int unsigned     integrals_checked = 0;
    int unsigned     mismatch_count    = 0;

    // Traffic shaping shared between the test tasks and the receiver
    bit              tx_steady   = 1'b0;
    bit              rx_steady   = 1'b0;
    int unsigned     output_hold = 0;

    current_loop_integrator_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .measured_current  (measured_current),
        .current_reference (current_reference),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .integral_value    (integral_value),
        .clamp_status      (clamp_status)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #(1_000_000);
        $display("current_loop_integrator_unit test failed");
        $finish;
    end

    // One integrator update. The error is the wrapped 16-bit difference read as
    // signed; Ki = gain / divisor. A zero divisor leaves the accumulator alone.
    function automatic integrator_out_t integrate_sample(
        input logic [IN_W-1:0] meas,
        input logic [IN_W-1:0] setpoint
    );
        integrator_out_t          res;
        logic [IN_W-1:0]          diff;
        int                       err;
        logic [ACC_W-1:0]         mag;
        logic [ACC_W-1:0]         ki;
        logic [ACC_W-1:0]         inc;
        logic [ACC_W-1:0]         whole_ext;
        logic [ACC_W-1:0]         sum;
        logic [ACC_W-1:0]         top;
        longint                   prod;
        logic                     both_pos;
        logic                     both_neg;
        res.status = CLAMP_NONE;
        if (div_shadow != '0)
        begin
            diff = meas - setpoint;
            err  = $signed(diff);
            mag  = (err < 0) ? -err : err;
            ki   = {1'b0, gain_shadow} / {16'd0, div_shadow};

            // Saturate the increment once |error| reaches 0x7fffffff / Ki
            if (ki != '0 && mag >= INC_POS_SAT / ki)
                inc = (err >= 0) ? INC_POS_SAT : INC_NEG_SAT;
            else
            begin
                prod = longint'(ki) * longint'(err);
                inc  = prod[ACC_W-1:0];
            end

            whole_ext = {{(ACC_W-WHOLE_W){acc_whole[WHOLE_W-1]}}, acc_whole};
            both_pos  = !inc[ACC_W-1] && !whole_ext[ACC_W-1];
            both_neg  =  inc[ACC_W-1] &&  whole_ext[ACC_W-1];

            sum = inc + (whole_ext << FRACTION_BITS) + ACC_W'(acc_frac);
            top = ACC_W'(limit_shadow) << FRACTION_BITS;

            // Same-sign overflow first, then the plain range clamp
            if (both_pos && sum[ACC_W-1])
            begin
                sum        = top;
                res.status = CLAMP_HIGH;
            end
            else if (both_neg && !sum[ACC_W-1])
            begin
                sum        = '0;
                res.status = CLAMP_LOW;
            end
            else if (sum[ACC_W-1])
            begin
                sum        = '0;
                res.status = CLAMP_LOW;
            end
            else if (sum >= top)
            begin
                sum        = top;
                res.status = CLAMP_HIGH;
            end

            acc_whole = sum[FRACTION_BITS +: WHOLE_W];
            acc_frac  = sum[FRACTION_BITS-1:0];
        end
        res.value = acc_whole[LIMIT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Tracks register writes and accepted samples, and checks every result item
    always @(posedge clk)
    begin : scoreboard
        integrator_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                integrals_checked++;
                if (expected_integrals.size() == 0)
                    report_mismatch("result with nothing outstanding", integral_value, 0);
                else
                begin
                    want = expected_integrals.pop_front();
                    if (integral_value !== want.value)
                        report_mismatch("integral_value", integral_value, want.value);
                    if (clamp_status !== want.status)
                        report_mismatch("clamp_status", clamp_status, want.status);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_SCALE:   gain_shadow  = cfg_data;
                    REG_KI_DIVISOR:   div_shadow   = cfg_data[DIV_W-1:0];
                    REG_OUTPUT_LIMIT: limit_shadow = cfg_data[LIMIT_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                expected_integrals.push_back(integrate_sample(measured_current,
                                                              current_reference));
        end
    end

    // Receiver: random stall before each result, or a long hold when asked.
    // out_ready only changes at most once per edge.
    initial
    begin : result_receiver
        int unsigned stall;
        forever
        begin
            stall       = output_hold;
            output_hold = 0;
            if (stall == 0)
                stall = rx_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one sample; valid stays high across back-to-back items
    task automatic send_sample(input logic [IN_W-1:0] meas, input logic [IN_W-1:0] setpoint);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        measured_current  <= meas;
        current_reference <= setpoint;
        do @(posedge clk); while (!in_ready);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Only called with the block idle
    task automatic configure(
        input logic [GAIN_W-1:0]  gain,
        input logic [DIV_W-1:0]   div,
        input logic [LIMIT_W-1:0] lim
    );
        write_reg(REG_GAIN_SCALE, gain);
        write_reg(REG_KI_DIVISOR, GAIN_W'(div));
        write_reg(REG_OUTPUT_LIMIT, GAIN_W'(lim));
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (integrals_checked < samples_sent)
            @(posedge clk);
    endtask

    // Error is mostly small so the integrator wanders rather than pinning
    task automatic send_random_sample();
        logic [IN_W-1:0] meas;
        logic [IN_W-1:0] err_word;
        int              err;
        meas = $urandom_range(0, 65535);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: err = int'($urandom_range(0, 128)) - 64;
            6, 7:             err = int'($urandom_range(0, 8192)) - 4096;
            default:          err = $urandom_range(0, 65535);
        endcase
        err_word = err[IN_W-1:0];
        send_sample(meas, meas - err_word);
    endtask

    task automatic pick_random_config();
        int unsigned div;
        int unsigned ki;
        int unsigned lim;
        longint      gain;
        div = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 65535);
        case ($urandom_range(0, 7))
            0:       ki = 0;
            6:       ki = $urandom_range(2000, 40000);
            default: ki = $urandom_range(1, 2000);
        endcase
        gain = longint'(ki) * div + $urandom_range(0, div - 1);
        if (gain > 64'h7fff_ffff)
            gain = 64'h7fff_ffff;
        if ($urandom_range(0, 7) == 0)
            gain = $urandom_range(0, 32'h7fff_ffff);
        case ($urandom_range(0, 7))
            0:       lim = 0;
            1:       lim = 32767;
            2:       lim = $urandom_range(1, 32767);
            default: lim = $urandom_range(1, 400);
        endcase
        configure(gain[GAIN_W-1:0], div[DIV_W-1:0], lim[LIMIT_W-1:0]);
    endtask

    // Out of reset the divisor is zero, so the integrator holds at zero
    task automatic test_reset_hold();
        send_sample(16'hffff, 16'h0000);
        send_sample(16'h0000, 16'hffff);
        drain_results();
    endtask

    // Ki rounds down to zero: only the clamp acts; limit zero pins at the top
    task automatic test_zero_gain();
        configure(31'd5, 16'd100, 15'd200);
        send_sample(16'h1234, 16'h1200);
        send_sample(16'h0000, 16'h0000);
        drain_results();
        configure(31'd0, 16'd1, 15'd0);
        send_sample(16'h8000, 16'h0001);
        drain_results();
    endtask

    // Ki at its maximum: any non-zero error saturates the increment
    task automatic test_saturation();
        configure(31'h7fff_ffff, 16'd1, 15'h7fff);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'h0000, 16'h0001);
        send_sample(16'h7fff, 16'h0000);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h1234, 16'h1234);
        drain_results();
    endtask

    // Fill to the top, then push past bit 31 so the sum flips sign
    task automatic test_sum_overflow();
        send_sample(16'h7fff, 16'h0000);
        drain_results();
        configure(31'd65536, 16'd1, 15'h7fff);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'h8000, 16'h0000);
        drain_results();
    endtask

    // Landing exactly on the limit reports a clamp
    task automatic test_limit_equal();
        configure(31'd65536, 16'd1, 15'd10);
        send_sample(16'h0009, 16'h0000);
        send_sample(16'h0001, 16'h0000);
        drain_results();
    endtask

    // Limit lowered under the held value clamps; a zero divisor then holds
    task automatic test_limit_lowered();
        configure(31'd0, 16'd1, 15'd3);
        send_sample(16'h0000, 16'h0000);
        drain_results();
        configure(31'd65536, 16'd0, 15'd3);
        send_sample(16'h0005, 16'h0000);
        drain_results();
    endtask

    // Largest divisor with largest gain: Ki of 32768, no saturation reachable
    task automatic test_max_divisor();
        configure(31'h7fff_ffff, 16'hffff, 15'h7fff);
        send_sample(16'hffff, 16'h7fff);
        send_sample(16'h7fff, 16'h0000);
        drain_results();
    endtask

    // Receiver holds off while samples keep coming, so the input stalls
    task automatic test_output_backpressure();
        configure(31'd7000, 16'd7, 15'd300);
        output_hold = 400;
        tx_steady   = 1'b1;
        repeat (10) send_random_sample();
        tx_steady   = 1'b0;
        drain_results();
    endtask

    // Bulk random traffic over a series of register settings
    task automatic test_random_phases();
        logic [31:0] rnd;
        for (int phase = 0; phase < 9; phase++)
        begin
            rnd = $urandom();
            if (phase == 0)
                configure(31'h7fff_ffff, 16'hffff, 15'h7fff);
            else if (phase == 1)
                configure(rnd[GAIN_W-1:0], 16'd0, rnd[LIMIT_W-1:0]);
            else
                pick_random_config();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat (50) send_random_sample();
            drain_results();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_hold();
        test_zero_gain();
        test_saturation();
        test_sum_overflow();
        test_limit_equal();
        test_limit_lowered();
        test_max_divisor();
        test_output_backpressure();
        test_random_phases();

        // Let any stray result show up before the verdict
        drain_results();
        repeat (64) @(posedge clk);
        if (expected_integrals.size() != 0)
            report_mismatch("results never delivered", expected_integrals.size(), 0);

        if (mismatch_count == 0)
            $display("current_loop_integrator_unit test passed");
        else
            $display("current_loop_integrator_unit test failed");
        $finish;
    end

endmodule
